FILE: design/tcch_pkg.sv
// shared constants, widths and the arctangent table for the compass heading pipeline
package tcch_pkg;

	// field and register widths
	localparam int MAG_W      = 13;
	localparam int ACC_W      = 16;
	localparam int OFF_W      = 16;
	localparam int DECL_W     = 19;
	localparam int FS_W       = 5;
	localparam int HEAD_W     = 15;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 19;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_OFF_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DECL  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FS    = 2'd3;

	// register reset values
	localparam logic [OFF_W-1:0]  OFF_X_RST = 16'd144;
	localparam logic [OFF_W-1:0]  OFF_Y_RST = 16'd312;
	localparam logic [DECL_W-1:0] DECL_RST  = 19'd15073;
	localparam logic [FS_W-1:0]   FS_RST    = 5'd2;

	// internal datapath widths
	localparam int MS_W   = 18;  // magnetometer in 1/16 count, x and y minus offset
	localparam int SP_W   = 17;  // signed Q1.15 including +-1.0
	localparam int AY_W   = 27;  // scaled accelerometer
	localparam int CP_W   = 16;  // unsigned Q1.15 including 1.0
	localparam int RAD_W  = 31;  // radicand and dividend
	localparam int SQRT_STEPS = 16;
	localparam int DIV_STEPS  = 16;
	localparam int VEC_W  = 54;  // tilt compensated vector
	localparam int CORD_W = 56;  // cordic x and y with growth headroom
	localparam int ANG_W  = 21;  // Q3.16 angle
	localparam int HW_W   = 23;  // heading before wrap

	// numeric constants
	localparam int ONE_Q15      = 32768;
	localparam int PI_Q16       = 205887;
	localparam int TWO_PI_Q16   = 411775;
	localparam int FULL_TURN_64 = 23040;
	localparam int ATAN_LEN     = 24;
	localparam int CORDIC_STAGES_DEF = 16;

	// reciprocal of a full turn for the degree conversion
	localparam int DEG_SHIFT = 48;
	localparam int DEG_N_W   = 35;
	localparam int DEG_M_W   = 30;
	localparam logic [DEG_M_W-1:0] DEG_RECIP =
		DEG_M_W'((64'd1 << DEG_SHIFT) / 64'(TWO_PI_Q16));

	// atan(2^-i) in Q3.16 radians
	function automatic logic [16:0] atan_q16(input int i);
		logic [16:0] v;
		case (i)
			0:       v = 17'd51472;
			1:       v = 17'd30386;
			2:       v = 17'd16055;
			3:       v = 17'd8150;
			4:       v = 17'd4091;
			5:       v = 17'd2047;
			6:       v = 17'd1024;
			7:       v = 17'd512;
			8:       v = 17'd256;
			9:       v = 17'd128;
			10:      v = 17'd64;
			11:      v = 17'd32;
			12:      v = 17'd16;
			13:      v = 17'd8;
			14:      v = 17'd4;
			15:      v = 17'd2;
			16:      v = 17'd1;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

endpackage

FILE: design/tcch_isqrt.sv
// pipelined integer square root, one result bit per stage, rounds down
module tcch_isqrt #(
	parameter int SW = 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_vld,
	input  logic [tcch_pkg::RAD_W-1:0] radicand,
	input  logic [SW-1:0]              in_side,
	output logic                       out_vld,
	output logic [tcch_pkg::CP_W-1:0]  root,
	output logic [SW-1:0]              out_side
);

	localparam int N = tcch_pkg::SQRT_STEPS;
	localparam int W = tcch_pkg::RAD_W;

	logic         vld_s  [N];
	logic [W-1:0] rem_s  [N];
	logic [W-1:0] root_s [N];
	logic [SW-1:0] side_s [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		localparam logic [W:0] BIT = (W+1)'(1) << (2 * (N - 1 - k));
		logic          vld_in;
		logic [W-1:0]  rem_in;
		logic [W-1:0]  root_in;
		logic [SW-1:0] side_in;
		logic [W:0]    trial;
		logic          ge;
		logic [W-1:0]  rem_nxt;
		logic [W-1:0]  root_nxt;

		if (k == 0) begin : g_first
			assign vld_in  = in_vld;
			assign rem_in  = radicand;
			assign root_in = '0;
			assign side_in = in_side;
		end else begin : g_next
			assign vld_in  = vld_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign side_in = side_s[k-1];
		end

		// one restoring step of the digit by digit root
		always_comb begin
			trial = {1'b0, root_in} + BIT;
			ge    = {1'b0, rem_in} >= trial;
			if (ge) begin
				rem_nxt  = W'({1'b0, rem_in} - trial);
				root_nxt = W'(({1'b0, root_in} >> 1) + BIT);
			end else begin
				rem_nxt  = rem_in;
				root_nxt = root_in >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= rem_nxt;
				root_s[k] <= root_nxt;
				side_s[k] <= side_in;
			end
		end
	end

	assign out_vld  = vld_s[N-1];
	assign root     = root_s[N-1][tcch_pkg::CP_W-1:0];
	assign out_side = side_s[N-1];

endmodule

FILE: design/tcch_div.sv
// pipelined restoring divider, one quotient bit per stage
module tcch_div #(
	parameter int SW = 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_vld,
	input  logic [tcch_pkg::RAD_W-1:0] num,
	input  logic [tcch_pkg::CP_W-1:0]  den,
	input  logic [SW-1:0]              in_side,
	output logic                       out_vld,
	output logic [tcch_pkg::CP_W-1:0]  quo,
	output logic [SW-1:0]              out_side
);

	localparam int N  = tcch_pkg::DIV_STEPS;
	localparam int W  = tcch_pkg::RAD_W;
	localparam int DW = tcch_pkg::CP_W;

	logic          vld_s  [N];
	logic [W-1:0]  rem_s  [N];
	logic [DW-1:0] den_s  [N];
	logic [N-1:0]  quo_s  [N];
	logic [SW-1:0] side_s [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		localparam int J = N - 1 - k;
		logic          vld_in;
		logic [W-1:0]  rem_in;
		logic [DW-1:0] den_in;
		logic [N-1:0]  quo_in;
		logic [SW-1:0] side_in;
		logic [W:0]    trial;
		logic          ge;
		logic [W-1:0]  rem_nxt;
		logic [N-1:0]  quo_nxt;

		if (k == 0) begin : g_first
			assign vld_in  = in_vld;
			assign rem_in  = num;
			assign den_in  = den;
			assign quo_in  = '0;
			assign side_in = in_side;
		end else begin : g_next
			assign vld_in  = vld_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign den_in  = den_s[k-1];
			assign quo_in  = quo_s[k-1];
			assign side_in = side_s[k-1];
		end

		// trial subtract of the shifted divisor
		always_comb begin
			trial   = (W+1)'(den_in) << J;
			ge      = {1'b0, rem_in} >= trial;
			rem_nxt = rem_in;
			quo_nxt = quo_in;
			if (ge) begin
				rem_nxt    = W'({1'b0, rem_in} - trial);
				quo_nxt[J] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= rem_nxt;
				den_s[k]  <= den_in;
				quo_s[k]  <= quo_nxt;
				side_s[k] <= side_in;
			end
		end
	end

	assign out_vld  = vld_s[N-1];
	assign quo      = DW'(quo_s[N-1]);
	assign out_side = side_s[N-1];

endmodule

FILE: design/tcch_cordic.sv
// pipelined vectoring cordic giving atan2(num, den) in Q3.16 radians
module tcch_cordic #(
	parameter int STAGES = tcch_pkg::CORDIC_STAGES_DEF,
	parameter int SW     = 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_vld,
	input  logic signed [tcch_pkg::VEC_W-1:0] num,
	input  logic signed [tcch_pkg::VEC_W-1:0] den,
	input  logic [SW-1:0]                     in_side,
	output logic                              out_vld,
	output logic signed [tcch_pkg::ANG_W-1:0] angle,
	output logic [SW-1:0]                     out_side
);

	localparam int CW = tcch_pkg::CORD_W;
	localparam int AW = tcch_pkg::ANG_W;
	localparam logic signed [AW-1:0] PI_A = AW'(tcch_pkg::PI_Q16);

	logic                 vld_s  [STAGES+1];
	logic signed [CW-1:0] x_s    [STAGES+1];
	logic signed [CW-1:0] y_s    [STAGES+1];
	logic signed [AW-1:0] z_s    [STAGES+1];
	logic                 zero_s [STAGES+1];
	logic [SW-1:0]        side_s [STAGES+1];

	logic signed [CW-1:0] x_in;
	logic signed [CW-1:0] y_in;

	assign x_in = CW'(den);
	assign y_in = CW'(num);

	// pre-rotation into the right half plane
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (x_in == '0) && (y_in == '0);
			side_s[0] <= in_side;
			if (x_in < 0) begin
				x_s[0] <= -x_in;
				y_s[0] <= -y_in;
				z_s[0] <= (y_in >= 0) ? PI_A : -PI_A;
			end else begin
				x_s[0] <= x_in;
				y_s[0] <= y_in;
				z_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		localparam logic signed [AW-1:0] ATAN = AW'(tcch_pkg::atan_q16(i));
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;

		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		// rotate toward the x axis
		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				side_s[i+1] <= side_s[i];
				if (y_s[i] < 0) begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - ATAN;
				end else begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + ATAN;
				end
			end
		end
	end

	assign out_vld  = vld_s[STAGES];
	assign angle    = zero_s[STAGES] ? '0 : z_s[STAGES];
	assign out_side = side_s[STAGES];

endmodule

FILE: design/tcch_deg.sv
// heading offset, wrap into one turn and conversion to 1/64 degree
module tcch_deg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               in_vld,
	input  logic signed [tcch_pkg::ANG_W-1:0]  angle,
	input  logic signed [tcch_pkg::DECL_W-1:0] decl,
	input  logic                               in_sat,
	output logic                               out_vld,
	output logic [tcch_pkg::HEAD_W-1:0]        heading,
	output logic                               out_sat
);

	localparam int HW = tcch_pkg::HW_W;
	localparam int NW = tcch_pkg::DEG_N_W;
	localparam int OW = tcch_pkg::HEAD_W;
	localparam logic signed [HW-1:0] PI_H  = HW'(tcch_pkg::PI_Q16);
	localparam logic signed [HW-1:0] TWO_H = HW'(tcch_pkg::TWO_PI_Q16);
	localparam logic [NW-1:0] TURN_N = NW'(tcch_pkg::TWO_PI_Q16);
	localparam logic [NW-1:0] HALF_N = NW'(tcch_pkg::TWO_PI_Q16 / 2);
	localparam logic [NW-1:0] DEG_N  = NW'(tcch_pkg::FULL_TURN_64);
	localparam int PW = NW + tcch_pkg::DEG_M_W;

	logic                 vld_d1, vld_d2, vld_d3, vld_d4, vld_d5, vld_d6;
	logic                 sat_d1, sat_d2, sat_d3, sat_d4, sat_d5, sat_d6;
	logic signed [HW-1:0] h0;
	logic signed [HW-1:0] h_d1;
	logic signed [HW-1:0] h_d2;
	logic [NW-1:0]        n_d3, n_d4, r_d5;
	logic [PW-1:0]        prod_d4;
	logic [OW-1:0]        qe;
	logic [OW-1:0]        q_d5;
	logic [OW-1:0]        head_d6;

	assign h0 = HW'(angle) - PI_H + HW'(decl);
	assign qe = prod_d4[tcch_pkg::DEG_SHIFT +: OW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_d1 <= 1'b0;
			vld_d2 <= 1'b0;
			vld_d3 <= 1'b0;
			vld_d4 <= 1'b0;
			vld_d5 <= 1'b0;
			vld_d6 <= 1'b0;
		end else if (en) begin
			vld_d1 <= in_vld;
			vld_d2 <= vld_d1;
			vld_d3 <= vld_d2;
			vld_d4 <= vld_d3;
			vld_d5 <= vld_d4;
			vld_d6 <= vld_d5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// first wrap step
			h_d1   <= (h0 < 0) ? h0 + TWO_H : h0;
			sat_d1 <= in_sat;
			// second wrap step, from above or below
			if (h_d1 < 0) begin
				h_d2 <= h_d1 + TWO_H;
			end else if (h_d1 > TWO_H) begin
				h_d2 <= h_d1 - TWO_H;
			end else begin
				h_d2 <= h_d1;
			end
			sat_d2 <= sat_d1;
			// scaled numerator with half turn for rounding
			n_d3   <= NW'(h_d2) * DEG_N + HALF_N;
			sat_d3 <= sat_d2;
			// reciprocal multiply, estimate is low by at most one
			prod_d4 <= PW'(n_d3) * PW'(tcch_pkg::DEG_RECIP);
			n_d4    <= n_d3;
			sat_d4  <= sat_d3;
			q_d5    <= qe;
			r_d5    <= n_d4 - NW'(qe) * TURN_N;
			sat_d5  <= sat_d4;
			// correction
			head_d6 <= q_d5 + OW'(r_d5 >= TURN_N);
			sat_d6  <= sat_d5;
		end
	end

	assign out_vld = vld_d6;
	assign heading = head_d6;
	assign out_sat = sat_d6;

endmodule

FILE: design/tilt_compensated_compass_heading.sv
// top level of the tilt compensated compass heading pipeline
//
//  channel | signals                                   | role
//  --------+-------------------------------------------+---------------------------
//  in      | in_valid in_ready mag_x mag_y mag_z       | one sensor sample
//          | accel_x accel_y                           |
//  out     | out_valid out_ready heading               | one heading per sample
//          | tilt_saturated                            |
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data    | register write, always ready
//
// a sample enters every cycle while in_ready is high;
// the deepest parts of the pipe are two 16 stage square roots, a 16 stage divider and the cordic.
// one advance enable moves every stage; it is high while the output register is empty
// or being taken, so a stall freezes the whole pipe and nothing is lost or repeated.
// reset clears the valid bits and loads the register defaults.
module tilt_compensated_compass_heading #(
	parameter int CORDIC_STAGES = tcch_pkg::CORDIC_STAGES_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [tcch_pkg::MAG_W-1:0]      mag_x,
	input  logic signed [tcch_pkg::MAG_W-1:0]      mag_y,
	input  logic signed [tcch_pkg::MAG_W-1:0]      mag_z,
	input  logic signed [tcch_pkg::ACC_W-1:0]      accel_x,
	input  logic signed [tcch_pkg::ACC_W-1:0]      accel_y,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [tcch_pkg::HEAD_W-1:0]            heading,
	output logic                                   tilt_saturated,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [tcch_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [tcch_pkg::CFG_DATA_W-1:0]        cfg_data
);

	localparam int MS = tcch_pkg::MS_W;
	localparam int SP = tcch_pkg::SP_W;
	localparam int AY = tcch_pkg::AY_W;
	localparam int CP = tcch_pkg::CP_W;
	localparam int RW = tcch_pkg::RAD_W;
	localparam int VW = tcch_pkg::VEC_W;

	// roll sine selection
	localparam logic [1:0] SR_DIV  = 2'd0;
	localparam logic [1:0] SR_POS  = 2'd1;
	localparam logic [1:0] SR_NEG  = 2'd2;
	localparam logic [1:0] SR_ZERO = 2'd3;

	localparam logic signed [AY-1:0] LIM_A  = AY'(tcch_pkg::ONE_Q15);
	localparam logic signed [SP-1:0] ONE_S  = SP'(tcch_pkg::ONE_Q15);
	localparam logic signed [33:0]   ONE_SQ = 34'(1) <<< 30;

	typedef struct packed {
		logic signed [MS-1:0] mx16;
		logic signed [MS-1:0] my16;
		logic signed [MS-1:0] mz16;
		logic signed [SP-1:0] sp;
		logic signed [AY-1:0] ay;
		logic                 sat;
	} a_side_t;

	typedef struct packed {
		logic signed [MS-1:0] mx16;
		logic signed [MS-1:0] my16;
		logic signed [MS-1:0] mz16;
		logic signed [SP-1:0] sp;
		logic [CP-1:0]        cp;
		logic [1:0]           code;
		logic                 neg;
		logic                 sat;
	} b_side_t;

	typedef struct packed {
		logic signed [MS-1:0] mx16;
		logic signed [MS-1:0] my16;
		logic signed [MS-1:0] mz16;
		logic signed [SP-1:0] sp;
		logic [CP-1:0]        cp;
		logic signed [SP-1:0] sr;
		logic                 sat;
	} c_side_t;

	// configuration registers
	logic signed [tcch_pkg::OFF_W-1:0]  off_x_q;
	logic signed [tcch_pkg::OFF_W-1:0]  off_y_q;
	logic signed [tcch_pkg::DECL_W-1:0] decl_q;
	logic [tcch_pkg::FS_W-1:0]          fs_q;

	logic adv;

	assign cfg_ready = 1'b1;
	assign adv       = !out_valid || out_ready;
	assign in_ready  = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_x_q <= tcch_pkg::OFF_X_RST;
			off_y_q <= tcch_pkg::OFF_Y_RST;
			decl_q  <= tcch_pkg::DECL_RST;
			fs_q    <= tcch_pkg::FS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tcch_pkg::REG_OFF_X: off_x_q <= cfg_data[tcch_pkg::OFF_W-1:0];
				tcch_pkg::REG_OFF_Y: off_y_q <= cfg_data[tcch_pkg::OFF_W-1:0];
				tcch_pkg::REG_DECL:  decl_q  <= cfg_data[tcch_pkg::DECL_W-1:0];
				tcch_pkg::REG_FS:    fs_q    <= cfg_data[tcch_pkg::FS_W-1:0];
				default: ;
			endcase
		end
	end

	// stage 1: scale accelerometer, clamp pitch sine, remove offsets
	logic signed [21:0] ax_mul;
	logic signed [21:0] ay_mul;
	logic signed [AY-1:0] sp_raw;
	logic signed [AY-1:0] ay_sc;
	logic signed [SP-1:0] sp_c;
	logic                 sat_c;

	assign ax_mul = accel_x * $signed({1'b0, fs_q});
	assign ay_mul = accel_y * $signed({1'b0, fs_q});
	assign sp_raw = -(AY'(ax_mul) <<< 4);
	assign ay_sc  = AY'(ay_mul) <<< 4;

	always_comb begin
		sp_c  = SP'(sp_raw);
		sat_c = 1'b0;
		if (sp_raw > LIM_A) begin
			sp_c  = ONE_S;
			sat_c = 1'b1;
		end else if (sp_raw < -LIM_A) begin
			sp_c  = -ONE_S;
			sat_c = 1'b1;
		end
	end

	logic    vld_s1;
	a_side_t a_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1.mx16 <= (MS'(mag_x) <<< 4) - MS'(off_x_q);
			a_s1.my16 <= (MS'(mag_y) <<< 4) - MS'(off_y_q);
			a_s1.mz16 <= MS'(mag_z) <<< 4;
			a_s1.sp   <= sp_c;
			a_s1.ay   <= ay_sc;
			a_s1.sat  <= sat_c;
		end
	end

	// stage 2: radicand for the pitch cosine
	logic signed [33:0] sp_sq;
	logic               vld_s2;
	logic [RW-1:0]      vp_s2;
	a_side_t            a_s2;

	assign sp_sq = a_s1.sp * a_s1.sp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vp_s2 <= RW'(ONE_SQ - sp_sq);
			a_s2  <= a_s1;
		end
	end

	// pitch cosine
	logic          qa_vld;
	logic [CP-1:0] cp_a;
	a_side_t       qa_side;

	tcch_isqrt #(.SW($bits(a_side_t))) u_sqrt_pitch (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (vld_s2),
		.radicand (vp_s2),
		.in_side  (a_s2),
		.out_vld  (qa_vld),
		.root     (cp_a),
		.out_side (qa_side)
	);

	// stage 3: roll sine case and divider operands
	logic signed [AY-1:0] cp_ext;
	logic signed [AY-1:0] ay_neg;
	logic signed [AY-1:0] ay_abs;
	logic [1:0]           code_c;

	assign cp_ext = AY'({1'b0, cp_a});
	assign ay_neg = -qa_side.ay;
	assign ay_abs = (qa_side.ay < 0) ? ay_neg : qa_side.ay;

	always_comb begin
		if (qa_side.ay > cp_ext) begin
			code_c = SR_POS;
		end else if (ay_neg > cp_ext) begin
			code_c = SR_NEG;
		end else if (cp_a == '0) begin
			code_c = SR_ZERO;
		end else begin
			code_c = SR_DIV;
		end
	end

	logic          vld_s3;
	logic [RW-1:0] num_s3;
	logic [CP-1:0] den_s3;
	b_side_t       b_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= qa_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s3    <= {ay_abs[CP-1:0], 15'd0};
			den_s3    <= cp_a;
			b_s3.mx16 <= qa_side.mx16;
			b_s3.my16 <= qa_side.my16;
			b_s3.mz16 <= qa_side.mz16;
			b_s3.sp   <= qa_side.sp;
			b_s3.cp   <= cp_a;
			b_s3.code <= code_c;
			b_s3.neg  <= qa_side.ay < 0;
			b_s3.sat  <= qa_side.sat || (code_c == SR_POS) || (code_c == SR_NEG);
		end
	end

	// roll sine quotient
	logic          qd_vld;
	logic [CP-1:0] quo_d;
	b_side_t       qd_side;

	tcch_div #(.SW($bits(b_side_t))) u_div_roll (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (vld_s3),
		.num      (num_s3),
		.den      (den_s3),
		.in_side  (b_s3),
		.out_vld  (qd_vld),
		.quo      (quo_d),
		.out_side (qd_side)
	);

	// stage 4: roll sine and radicand for the roll cosine
	logic signed [SP-1:0] sr_c;
	logic signed [SP-1:0] q_ext;
	logic signed [33:0]   sr_sq;

	assign q_ext = SP'({1'b0, quo_d});

	always_comb begin
		case (qd_side.code)
			SR_POS:  sr_c = ONE_S;
			SR_NEG:  sr_c = -ONE_S;
			SR_ZERO: sr_c = '0;
			default: sr_c = qd_side.neg ? -q_ext : q_ext;
		endcase
	end

	assign sr_sq = sr_c * sr_c;

	logic          vld_s4;
	logic [RW-1:0] vr_s4;
	c_side_t       c_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= qd_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vr_s4     <= RW'(ONE_SQ - sr_sq);
			c_s4.mx16 <= qd_side.mx16;
			c_s4.my16 <= qd_side.my16;
			c_s4.mz16 <= qd_side.mz16;
			c_s4.sp   <= qd_side.sp;
			c_s4.cp   <= qd_side.cp;
			c_s4.sr   <= sr_c;
			c_s4.sat  <= qd_side.sat;
		end
	end

	// roll cosine
	logic          qb_vld;
	logic [CP-1:0] cr_b;
	c_side_t       qb_side;

	tcch_isqrt #(.SW($bits(c_side_t))) u_sqrt_roll (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (vld_s4),
		.radicand (vr_s4),
		.in_side  (c_s4),
		.out_vld  (qb_vld),
		.root     (cr_b),
		.out_side (qb_side)
	);

	// stage 5: first rank of products
	logic signed [SP-1:0] cp_s;
	logic signed [SP-1:0] cr_s;
	logic signed [33:0]   ssp_c;
	logic signed [33:0]   scp_c;

	assign cp_s  = SP'({1'b0, qb_side.cp});
	assign cr_s  = SP'({1'b0, cr_b});
	assign ssp_c = qb_side.sr * qb_side.sp;
	assign scp_c = qb_side.sr * cp_s;

	logic                 vld_s5, sat_s5;
	logic signed [34:0]   mxcp_s5, mzsp_s5, mycr_s5;
	logic signed [31:0]   ssp_s5, scp_s5;
	logic signed [MS-1:0] mx16_s5, mz16_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= qb_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mxcp_s5 <= qb_side.mx16 * cp_s;
			mzsp_s5 <= qb_side.mz16 * qb_side.sp;
			mycr_s5 <= qb_side.my16 * cr_s;
			ssp_s5  <= ssp_c[31:0];
			scp_s5  <= scp_c[31:0];
			mx16_s5 <= qb_side.mx16;
			mz16_s5 <= qb_side.mz16;
			sat_s5  <= qb_side.sat;
		end
	end

	// stage 6: second rank of products and the x partial sum
	logic               vld_s6, sat_s6;
	logic signed [49:0] t1_s6, t3_s6;
	logic signed [35:0] xp_s6;
	logic signed [34:0] mycr_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t1_s6   <= mx16_s5 * ssp_s5;
			t3_s6   <= mz16_s5 * scp_s5;
			xp_s6   <= 36'(mxcp_s5) + 36'(mzsp_s5);
			mycr_s6 <= mycr_s5;
			sat_s6  <= sat_s5;
		end
	end

	// stage 7: tilt compensated vector
	logic                 vld_s7, sat_s7;
	logic signed [VW-1:0] xh_s7, yh_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xh_s7  <= VW'(xp_s6) <<< 15;
			yh_s7  <= VW'(t1_s6) + (VW'(mycr_s6) <<< 15) - VW'(t3_s6);
			sat_s7 <= sat_s6;
		end
	end

	// heading angle
	logic                                qc_vld;
	logic signed [tcch_pkg::ANG_W-1:0]   ang_c;
	logic                                qc_sat;

	tcch_cordic #(.STAGES(CORDIC_STAGES), .SW(1)) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (vld_s7),
		.num      (xh_s7),
		.den      (yh_s7),
		.in_side  (sat_s7),
		.out_vld  (qc_vld),
		.angle    (ang_c),
		.out_side (qc_sat)
	);

	// wrap, degrees and the output register
	tcch_deg u_deg (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_vld  (qc_vld),
		.angle   (ang_c),
		.decl    (decl_q),
		.in_sat  (qc_sat),
		.out_vld (out_valid),
		.heading (heading),
		.out_sat (tilt_saturated)
	);

endmodule
